[rtl/core/utc2ep_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc2ep_pkg: shared types, constants and helpers for calendar conversion
// Widths, calendar constants, the month table and the divide-by-100 helper.
// ----------------------------------------------------------------------------
package utc2ep_pkg;

  // Port field widths
  localparam int YEARS_IN_W = 13;
  localparam int MONTH_W    = 4;
  localparam int MDAY_W     = 5;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int SECOND_W   = 6;
  localparam int SECS_W     = 38;

  // Internal widths
  localparam int YEAR_W     = 14;   // full calendar year, up to 10091
  localparam int QUOT_W     = 8;    // year / 100, up to 100
  localparam int LEAPS_W    = 12;   // leap years in 1..year-1
  localparam int MDAYS_W    = 9;    // days before a month start
  localparam int DAYS_W     = 22;   // day count since epoch, plus day of month
  localparam int TOD_W      = 17;   // seconds within the day

  // Calendar constants
  localparam int YEAR_BASE    = 1900;
  localparam int EPOCH_YEAR   = 1970;
  localparam int DAYS_COMMON  = 365;
  localparam int DAYS_LEAP    = 366;
  localparam int MONTH_CLAMP  = 12;
  localparam int MONTH_MARCH  = 2;
  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_DAY  = 86400;
  localparam int LEAPS_BEFORE_EPOCH =
    (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;

  // Reciprocal for n / 100: exact for n below 2^20 / 48
  localparam int DIV100_SHIFT = 20;
  localparam int DIV100_MUL   = (1 << DIV100_SHIFT) / 100 + 1;

  // Default depth of the queue between front and back
  localparam int Q_DEPTH_DEF = 4;

  typedef struct packed {
    logic [DAYS_W-1:0] days;   // whole days plus day of month (one-based)
    logic [TOD_W-1:0]  tod;    // hour, minute and second in seconds
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Divide a year-sized value by 100 through a reciprocal multiply
  function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] n);
    logic [2*YEAR_W-1:0] prod;
    prod = (2*YEAR_W)'(n) * (2*YEAR_W)'(DIV100_MUL);
    return prod[DIV100_SHIFT +: QUOT_W];
  endfunction

  // Days before the start of a month in a common year; twelve means full year
  function automatic logic [MDAYS_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MDAYS_W-1:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = MDAYS_W'(DAYS_COMMON);
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/core/utc_calendar_to_epoch_seconds.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc_calendar_to_epoch_seconds: broken-down UTC time to Unix epoch seconds
// Gregorian leap counting by reciprocal division, month table, time of day.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | input     | in_valid / in_stall | year, month, day, h, m, s fields
//  out_    | output    | out_valid/out_stall | out_epoch_seconds (38 bits)
//
//  One conversion per cycle while the output does not stall; through an empty
//  pipe a beat passes the front register, queue write, multiply stage and output register.
//  The 22x17 day-to-seconds multiply has a stage of its own.
//  Reset is synchronous, active low; it empties every stage and the queue.
//  An output stall backs up into the queue; the input stalls only once the
//  queue is full and the front register holds a beat.
//
// ----------------------------------------------------------------------------
module utc_calendar_to_epoch_seconds #(
  parameter int QUEUE_DEPTH = utc2ep_pkg::Q_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [utc2ep_pkg::YEARS_IN_W-1:0]    in_years_since_1900,
  input  wire [utc2ep_pkg::MONTH_W-1:0]       in_month_index,
  input  wire [utc2ep_pkg::MDAY_W-1:0]        in_day_of_month,
  input  wire [utc2ep_pkg::HOUR_W-1:0]        in_hour_of_day,
  input  wire [utc2ep_pkg::MINUTE_W-1:0]      in_minute_of_hour,
  input  wire [utc2ep_pkg::SECOND_W-1:0]      in_second_of_minute,
  // Result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [utc2ep_pkg::SECS_W-1:0]       out_epoch_seconds
);
  import utc2ep_pkg::*;

  q_status_t q_st;
  q_entry_t  q_wdata, q_rdata;
  logic      q_push, q_pop;

  // Front: take each beat, classify the year, push days and time of day
  utc2ep_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_years_since_1900 (in_years_since_1900),
    .in_month_index      (in_month_index),
    .in_day_of_month     (in_day_of_month),
    .in_hour_of_day      (in_hour_of_day),
    .in_minute_of_hour   (in_minute_of_hour),
    .in_second_of_minute (in_second_of_minute),
    .q_st                (q_st),
    .q_push              (q_push),
    .q_wdata             (q_wdata)
  );

  // Queue: decouple the front from output stalls
  utc2ep_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .st    (q_st)
  );

  // Back: scale days to seconds, add time of day, drop the day offset
  utc2ep_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_st              (q_st),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds)
  );

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Queue status flags are never both set
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_st.full && q_st.empty))
    else $error("queue full and empty at once");

  // The input stalls only behind a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_st.full)
    else $error("input stalled with room in queue");

endmodule
`default_nettype wire

[rtl/core/utc2ep_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc2ep_front: input stage and day classification
// Registers the fields with the year quotients, then forms the day count
// and time of day and pushes them into the queue.
// ----------------------------------------------------------------------------
module utc2ep_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [utc2ep_pkg::YEARS_IN_W-1:0]    in_years_since_1900,
  input  wire [utc2ep_pkg::MONTH_W-1:0]       in_month_index,
  input  wire [utc2ep_pkg::MDAY_W-1:0]        in_day_of_month,
  input  wire [utc2ep_pkg::HOUR_W-1:0]        in_hour_of_day,
  input  wire [utc2ep_pkg::MINUTE_W-1:0]      in_minute_of_hour,
  input  wire [utc2ep_pkg::SECOND_W-1:0]      in_second_of_minute,
  input  utc2ep_pkg::q_status_t               q_st,
  output logic                                q_push,
  output utc2ep_pkg::q_entry_t                q_wdata
);
  import utc2ep_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [YEAR_W-1:0]     year_r;
  logic [QUOT_W-1:0]     q_y_r, q_ym1_r, q_ym1_4_r;
  logic [MONTH_W-1:0]    mon_r;
  logic [MDAY_W-1:0]     mday_r;
  logic [HOUR_W-1:0]     hour_r;
  logic [MINUTE_W-1:0]   min_r;
  logic [SECOND_W-1:0]   sec_r;

  logic [YEAR_W-1:0]     year_in, ym1_in, ym1_cur;
  logic                  adv;

  logic                  rem100_zero, leap;
  logic [LEAPS_W-1:0]    leaps_ym1;
  logic [YEAR_W-2:0]     yrs_since_epoch;
  logic [DAYS_W-1:0]     year_days;
  logic [MONTH_W-1:0]    mon_c;
  logic [MDAYS_W-1:0]    mon_days;
  logic                  leap_add;

  assign year_in = YEAR_W'(in_years_since_1900) + YEAR_W'(YEAR_BASE);
  assign ym1_in  = year_in - YEAR_W'(1);

  // Hold the stage while the queue is full
  assign adv      = !valid_r || !q_st.full;
  assign in_stall = valid_r && q_st.full;
  assign q_push   = valid_r && !q_st.full;
  assign valid_nxt = adv ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      year_r    <= year_in;
      q_y_r     <= div100(year_in);
      q_ym1_r   <= div100(ym1_in);
      q_ym1_4_r <= div100({2'b00, ym1_in[YEAR_W-1:2]});
      mon_r     <= in_month_index;
      mday_r    <= in_day_of_month;
      hour_r    <= in_hour_of_day;
      min_r     <= in_minute_of_hour;
      sec_r     <= in_second_of_minute;
    end
  end

  // Classify the year: leap flag and whole-year day count since the epoch
  always_comb begin
    ym1_cur     = year_r - YEAR_W'(1);
    rem100_zero = (year_r == YEAR_W'(YEAR_W'(q_y_r) * YEAR_W'(100)));
    leap        = (year_r[1:0] == 2'b00) && (!rem100_zero || (q_y_r[1:0] == 2'b00));
    leaps_ym1   = LEAPS_W'(ym1_cur[YEAR_W-1:2]) - LEAPS_W'(q_ym1_r) + LEAPS_W'(q_ym1_4_r);
    yrs_since_epoch = (YEAR_W-1)'(year_r - YEAR_W'(EPOCH_YEAR));
    if (year_r > YEAR_W'(EPOCH_YEAR)) begin
      year_days = DAYS_W'(yrs_since_epoch) * DAYS_W'(DAYS_COMMON)
                + DAYS_W'(leaps_ym1) - DAYS_W'(LEAPS_BEFORE_EPOCH);
    end else begin
      year_days = '0;
    end
    mon_c    = (mon_r > MONTH_W'(MONTH_CLAMP)) ? MONTH_W'(MONTH_CLAMP) : mon_r;
    mon_days = month_start(mon_c);
    leap_add = leap && (mon_c >= MONTH_W'(MONTH_MARCH));

    q_wdata.days = year_days + DAYS_W'(mon_days) + DAYS_W'(leap_add) + DAYS_W'(mday_r);
    q_wdata.tod  = TOD_W'(hour_r) * TOD_W'(SEC_PER_HOUR)
                 + TOD_W'(min_r) * TOD_W'(SEC_PER_MIN) + TOD_W'(sec_r);
  end

endmodule
`default_nettype wire

[rtl/core/utc2ep_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc2ep_fifo: short queue between front and back
// Register-based circular buffer with a fill count; push and pop may coincide.
// ----------------------------------------------------------------------------
module utc2ep_fifo #(
  parameter int DEPTH = utc2ep_pkg::Q_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  utc2ep_pkg::q_entry_t   wdata,
  input  wire                    pop,
  output utc2ep_pkg::q_entry_t   rdata,
  output utc2ep_pkg::q_status_t  st
);
  import utc2ep_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign st.full  = (cnt_r == CNT_W'(DEPTH));
  assign st.empty = (cnt_r == '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

[rtl/core/utc2ep_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc2ep_back: seconds assembly and output register
// Scales the day count to seconds, adds the time of day, removes the
// one-based day offset with a floor at zero, and holds the result.
// ----------------------------------------------------------------------------
module utc2ep_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  utc2ep_pkg::q_status_t            q_st,
  input  utc2ep_pkg::q_entry_t             q_rdata,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [utc2ep_pkg::SECS_W-1:0]    out_epoch_seconds
);
  import utc2ep_pkg::*;

  logic               a_valid_r, a_valid_nxt;
  logic [SECS_W-1:0]  prod_r;
  logic [TOD_W-1:0]   tod_r;
  logic               o_valid_r, o_valid_nxt;
  logic [SECS_W-1:0]  secs_r;

  logic               adv_a, adv_o;
  logic [SECS_W:0]    sum;
  logic [SECS_W-1:0]  secs_nxt;

  assign adv_o = !o_valid_r || !out_stall;
  assign adv_a = !a_valid_r || adv_o;
  assign q_pop = !q_st.empty && adv_a;

  assign a_valid_nxt = adv_a ? !q_st.empty : a_valid_r;
  assign o_valid_nxt = adv_o ? a_valid_r : o_valid_r;

  always_comb begin
    sum = (SECS_W+1)'(prod_r) + (SECS_W+1)'(tod_r);
    if (sum < (SECS_W+1)'(SEC_PER_DAY)) begin
      secs_nxt = '0;
    end else begin
      secs_nxt = SECS_W'(sum - (SECS_W+1)'(SEC_PER_DAY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r <= SECS_W'(q_rdata.days) * SECS_W'(SEC_PER_DAY);
      tod_r  <= q_rdata.tod;
    end
    if (adv_o && a_valid_r) begin
      secs_r <= secs_nxt;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_epoch_seconds = secs_r;

endmodule
`default_nettype wire

[bench/tb_utc_calendar_to_epoch_seconds.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utc_calendar_to_epoch_seconds: self-checking bench for the UTC converter
// Drives calendar beats through the valid/stall input, predicts each epoch
// second count in order and compares it against every result beat. A short
// directed table comes first, then constrained-by-hand random beats, with
// random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_utc_calendar_to_epoch_seconds;
  import utc2ep_pkg::*;

  // Run shape
  localparam int RANDOM_BEATS  = 1800;
  localparam int WATCHDOG_MAX  = 2000;  // cycles with no beat on either side
  localparam int HOLDOFF_AT    = 500;   // result beats seen before the long hold
  localparam int HOLDOFF_LEN   = 200;   // cycles the receiver holds off
  localparam int DRAIN_CYCLES  = 20;    // drain margin past the front, queue, multiply and output stages

  // One calendar beat plus an optional hand-typed answer
  typedef struct packed {
    logic [YEARS_IN_W-1:0] yrs;
    logic [MONTH_W-1:0]    mon;
    logic [MDAY_W-1:0]     mday;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic [SECOND_W-1:0]   sec;
    logic                  typed;
    logic [SECS_W-1:0]     secs;
  } cal_row_t;

  // Days before each month start in a common year; index twelve is a year
  int month_first_day [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                               304, 334, 365};

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_stall;
  logic [YEARS_IN_W-1:0] in_years_since_1900;
  logic [MONTH_W-1:0]    in_month_index;
  logic [MDAY_W-1:0]     in_day_of_month;
  logic [HOUR_W-1:0]     in_hour_of_day;
  logic [MINUTE_W-1:0]   in_minute_of_hour;
  logic [SECOND_W-1:0]   in_second_of_minute;
  logic                  out_valid;
  logic                  out_stall;
  logic [SECS_W-1:0]     out_epoch_seconds;

  // Answer for the beat currently on the input port; it changes together with
  // the payload, so it is always the answer for what the block sees.
  logic [SECS_W-1:0]     offered_secs;

  logic [SECS_W-1:0]     pending_secs_q [$];   // answers in flight, oldest first
  cal_row_t              directed_q [$];
  int                    mismatches = 0;
  int                    results_seen = 0;
  int                    quiet_cycles = 0;
  bit                    steady = 1'b0;        // no idling on either side

  utc_calendar_to_epoch_seconds DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_years_since_1900 (in_years_since_1900),
    .in_month_index      (in_month_index),
    .in_day_of_month     (in_day_of_month),
    .in_hour_of_day      (in_hour_of_day),
    .in_minute_of_hour   (in_minute_of_hour),
    .in_second_of_minute (in_second_of_minute),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_epoch_seconds   (out_epoch_seconds)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Gregorian leap years in 1..n
  function automatic longint leaps_upto(input longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic logic [SECS_W-1:0] epoch_seconds_of(input cal_row_t r);
    longint year;
    longint days;
    longint total;
    int     m;
    year = longint'(r.yrs) + YEAR_BASE;
    days = 0;
    // Years before the epoch add no whole-year days at all
    if (year > EPOCH_YEAR) begin
      days = DAYS_COMMON * (year - EPOCH_YEAR)
           + leaps_upto(year - 1) - leaps_upto(EPOCH_YEAR - 1);
    end
    // Month indexes past December count as the full year
    m = (r.mon > MONTH_CLAMP) ? MONTH_CLAMP : int'(r.mon);
    days += month_first_day[m];
    if (m >= MONTH_MARCH && year % 4 == 0 && (year % 100 != 0 || year % 400 == 0)) begin
      days += 1;
    end
    // Day zero steps back one day; no month-length check
    days += longint'(r.mday) - 1;
    total = days * SEC_PER_DAY + longint'(r.hour) * SEC_PER_HOUR
          + longint'(r.minute) * SEC_PER_MIN + longint'(r.sec);
    // Only day zero of January in a year up to 1970 can go negative: clamp
    if (total < 0) begin
      total = 0;
    end
    return total[SECS_W-1:0];
  endfunction

  function automatic cal_row_t make_row(input int y, input int mo, input int d,
                                        input int h, input int mi, input int s,
                                        input bit typed = 1'b0,
                                        input longint secs = 0);
    cal_row_t r;
    r.yrs    = YEARS_IN_W'(y);
    r.mon    = MONTH_W'(mo);
    r.mday   = MDAY_W'(d);
    r.hour   = HOUR_W'(h);
    r.minute = MINUTE_W'(mi);
    r.sec    = SECOND_W'(s);
    r.typed  = typed;
    r.secs   = SECS_W'(secs);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly legal calendar values, weighted toward the epoch, century years and
  // leap years; a tenth of month and time fields use a wider range, a twentieth of days are zero.
  function automatic cal_row_t random_row();
    cal_row_t r;
    int       y;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: y = $urandom_range(0, 8099);
      4:          y = $urandom_range(60, 80);
      5:          y = 100 * $urandom_range(1, 80) + $urandom_range(0, 8) - 4;
      6:          y = $urandom_range(8090, 8099);
      7:          y = $urandom_range(0, 8191);
      default:    y = 4 * $urandom_range(0, 2024);
    endcase
    r = make_row(y,
                 ($urandom_range(0, 9) != 0) ? $urandom_range(0, 11) : $urandom_range(12, 15),
                 ($urandom_range(0, 19) != 0) ? $urandom_range(1, 31) : 0,
                 ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 31),
                 ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 63),
                 ($urandom_range(0, 9) != 0) ? $urandom_range(0, 60) : $urandom_range(0, 63));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Present one beat, hold it until accepted, then maybe idle. Valid stays up
  // between back-to-back beats so it is never dropped and raised in one step.
  task automatic offer_beat(input cal_row_t r);
    int gap;
    in_valid            <= 1'b1;
    in_years_since_1900 <= r.yrs;
    in_month_index      <= r.mon;
    in_day_of_month     <= r.mday;
    in_hour_of_day      <= r.hour;
    in_minute_of_hour   <= r.minute;
    in_second_of_minute <= r.sec;
    offered_secs        <= r.typed ? r.secs : epoch_seconds_of(r);
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off to back the block up
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit held_off;
    int gap;
    held_off = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= HOLDOFF_AT) begin
        // Hold off long enough for the queue and front register to fill and
        // the input to stall while the sender keeps offering.
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLDOFF_LEN) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking and watchdog. Outputs are sampled at the edge, before any update
  // of that edge lands, so the order of processes in a step does not matter.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [SECS_W-1:0] got,
                                 input logic [SECS_W-1:0] want);
    $display("mismatch at %0t: %s: epoch_seconds got %0d want %0d", $realtime, what,
             got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic [SECS_W-1:0] want;
    bit                moved;
    moved = 1'b0;
    if (rst_n === 1'b1) begin
      // Check the result beat first: it can never belong to a beat accepted
      // at this same edge.
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        moved = 1'b1;
        results_seen++;
        if (pending_secs_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_epoch_seconds, '0);
        end else begin
          want = pending_secs_q.pop_front();
          if (out_epoch_seconds !== want) begin
            report_mismatch("wrong value", out_epoch_seconds, want);
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        moved = 1'b1;
        pending_secs_q.push_back(offered_secs);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", quiet_cycles,
               pending_secs_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cal_row_t r;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_years_since_1900 <= '0;
    in_month_index      <= '0;
    in_day_of_month     <= '0;
    in_hour_of_day      <= '0;
    in_minute_of_hour   <= '0;
    in_second_of_minute <= '0;
    offered_secs        <= '0;

    // Directed table. Answers typed only where plain from the definition:
    // the epoch itself, one day or one leap second after it, and results of zero.
    directed_q.push_back(make_row(70, 0, 1, 0, 0, 0, 1'b1, 0));        // epoch
    directed_q.push_back(make_row(70, 0, 2, 0, 0, 0, 1'b1, 86400));    // one day on
    directed_q.push_back(make_row(70, 0, 1, 0, 0, 60, 1'b1, 60));      // leap second
    directed_q.push_back(make_row(70, 0, 0, 0, 0, 0, 1'b1, 0));        // day zero: clamp
    directed_q.push_back(make_row(70, 0, 0, 23, 59, 59, 1'b1, 0));     // one second short
    directed_q.push_back(make_row(0, 0, 0, 0, 0, 0, 1'b1, 0));         // 1900, day zero
    directed_q.push_back(make_row(0, 0, 1, 0, 0, 0, 1'b1, 0));         // pre-epoch year
    directed_q.push_back(make_row(0, 2, 1, 0, 0, 0));                  // 1900 not leap
    directed_q.push_back(make_row(69, 11, 31, 23, 59, 59));            // eve of epoch
    directed_q.push_back(make_row(68, 2, 1, 0, 0, 0));                 // pre-epoch leap year, March 1
    directed_q.push_back(make_row(0, 13, 5, 1, 2, 3));                 // month past December
    directed_q.push_back(make_row(71, 0, 1, 0, 0, 0));                 // one whole year
    directed_q.push_back(make_row(70, 1, 31, 0, 0, 0));                // day past month end
    directed_q.push_back(make_row(70, 0, 1, 31, 63, 63));              // time fields maxed
    directed_q.push_back(make_row(104, 1, 29, 12, 0, 0));              // 2004 Feb 29
    directed_q.push_back(make_row(104, 2, 1, 0, 0, 0));                // after leap day
    directed_q.push_back(make_row(100, 2, 1, 0, 0, 0));                // 2000 leap
    directed_q.push_back(make_row(200, 2, 1, 0, 0, 0));                // 2100 not leap
    directed_q.push_back(make_row(130, 12, 1, 0, 0, 0));               // month twelve
    directed_q.push_back(make_row(8099, 11, 31, 23, 59, 59));          // end of 9999
    directed_q.push_back(make_row(8099, 12, 31, 23, 59, 60));          // month twelve, 9999
    directed_q.push_back(make_row(8099, 15, 31, 31, 63, 63));          // all fields high
    directed_q.push_back(make_row(8191, 15, 31, 31, 63, 63));          // year field full
    directed_q.push_back(make_row(8191, 0, 0, 0, 0, 0));               // full year, day zero

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) begin
      offer_beat(directed_q[i]);
    end

    // Random part; one stretch runs without idling on either side
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      steady = (n >= 900 && n < 1100);
      r = random_row();
      offer_beat(r);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain; the watchdog bounds this wait
    wait (pending_secs_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[utc_calendar_to_epoch_seconds.f]
rtl/core/utc2ep_pkg.sv
rtl/core/utc2ep_front.sv
rtl/core/utc2ep_fifo.sv
rtl/core/utc2ep_back.sv
rtl/core/utc_calendar_to_epoch_seconds.sv
bench/tb_utc_calendar_to_epoch_seconds.sv
